### src/directory_archive_deframer_top_defines.svh
// Assertion macros shared by the deframer RTL.
// DAD_ASSERT checks on every rising aclk edge outside reset.
// DAD_ASSERT_ALWAYS checks on every rising aclk edge, reset included.
`ifndef DIRECTORY_ARCHIVE_DEFRAMER_TOP_DEFINES_SVH
`define DIRECTORY_ARCHIVE_DEFRAMER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define DAD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define DAD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DAD_ASSERT(lbl, prop, msg)
`define DAD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### src/dad_pkg.sv
`default_nettype none

package dad_pkg;

    localparam int LENGTH_BITS_DEF = 32;
    localparam int APB_ADDR_BITS   = 4;
    localparam int APB_DATA_BITS   = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_SEPARATOR = 2'd0;
    localparam logic [1:0] REG_DIR_MARK  = 2'd1;
    localparam logic [1:0] REG_FILE_MARK = 2'd2;

    // byte kinds
    localparam logic [3:0] KIND_MARKER     = 4'd0;
    localparam logic [3:0] KIND_DIR_NAME   = 4'd1;
    localparam logic [3:0] KIND_DIR_END    = 4'd2;
    localparam logic [3:0] KIND_FILE_NAME  = 4'd3;
    localparam logic [3:0] KIND_LEN_DIGIT  = 4'd4;
    localparam logic [3:0] KIND_LEN_END    = 4'd5;
    localparam logic [3:0] KIND_CONTENT    = 4'd6;
    localparam logic [3:0] KIND_FILE_END   = 4'd7;
    localparam logic [3:0] KIND_EMPTY_SKIP = 4'd8;
    localparam logic [3:0] KIND_ERROR      = 4'd9;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PARSE = 2'd1;
    localparam logic [1:0] ERR_SIZE  = 2'd2;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;

    typedef struct packed {
        logic [7:0] separator_byte;
        logic [7:0] directory_marker;
        logic [7:0] file_marker;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  byte_kind;
        logic [7:0]  echo_byte;
        logic [31:0] file_length;
        logic [1:0]  error_code;
    } res_t;

endpackage

`default_nettype wire

### src/dad_cfg.sv
`default_nettype none

module dad_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [dad_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  wire logic [dad_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic      [dad_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                      pready,
    output dad_pkg::cfg_t                             cfg
);
    import dad_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_SEPARATOR: cfg_next.separator_byte   = pwdata[7:0];
                REG_DIR_MARK:  cfg_next.directory_marker = pwdata[7:0];
                REG_FILE_MARK: cfg_next.file_marker      = pwdata[7:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.separator_byte   <= 8'd0;
            cfg_reg.directory_marker <= 8'd68;
            cfg_reg.file_marker      <= 8'd70;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SEPARATOR: prdata = {24'd0, cfg_reg.separator_byte};
            REG_DIR_MARK:  prdata = {24'd0, cfg_reg.directory_marker};
            REG_FILE_MARK: prdata = {24'd0, cfg_reg.file_marker};
            default:       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### src/dad_parser.sv
`default_nettype none

module dad_parser #(
    parameter int LENGTH_BITS = dad_pkg::LENGTH_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    input  wire logic [7:0]    data_byte,
    input  wire logic          start_flag,
    input  wire dad_pkg::cfg_t cfg,
    output dad_pkg::res_t      res
);
    import dad_pkg::*;

    `include "directory_archive_deframer_top_defines.svh"

    localparam int WIDE = LENGTH_BITS + 4;

    typedef enum logic [7:0] {
        PH_AWAIT     = 8'b0000_0001,
        PH_DIR_NAME  = 8'b0000_0010,
        PH_FILE_NAME = 8'b0000_0100,
        PH_LENGTH    = 8'b0000_1000,
        PH_CONTENT   = 8'b0001_0000,
        PH_SKIP      = 8'b0010_0000,
        PH_ERR_PARSE = 8'b0100_0000,
        PH_ERR_SIZE  = 8'b1000_0000
    } phase_t;

    // length_reg holds the parsed length, then counts down the content bytes left
    phase_t                 phase_reg, phase_next, phase_eff;
    logic [LENGTH_BITS-1:0] length_reg, length_next, length_eff;
    logic                   digit_seen_reg, digit_seen_next, digit_eff;

    logic                   is_sep;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [WIDE-1:0]        len_wide;
    logic [WIDE-1:0]        scaled;
    logic                   overflow;
    logic [LENGTH_BITS+31:0] flen_wide;

    assign is_sep    = (data_byte == cfg.separator_byte);
    assign is_digit  = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
    assign digit     = 4'(data_byte - ASCII_ZERO);

    // start clears the parser before this byte is handled
    assign phase_eff  = start_flag ? PH_AWAIT : phase_reg;
    assign length_eff = start_flag ? '0 : length_reg;
    assign digit_eff  = start_flag ? 1'b0 : digit_seen_reg;

    // length * 10 + digit with four guard bits to catch overflow
    assign len_wide  = {4'd0, length_eff};
    assign scaled    = (len_wide << 3) + (len_wide << 1) + WIDE'(digit);
    assign overflow  = |scaled[WIDE-1:LENGTH_BITS];
    assign flen_wide = {32'd0, length_eff};

    always_comb begin
        phase_next      = phase_eff;
        length_next     = length_eff;
        digit_seen_next = digit_eff;
        res.byte_kind   = KIND_ERROR;
        res.echo_byte   = data_byte;
        res.file_length = 32'd0;
        res.error_code  = ERR_NONE;

        case (phase_eff)
            PH_AWAIT: begin
                if (data_byte == cfg.directory_marker) begin
                    phase_next    = PH_DIR_NAME;
                    res.byte_kind = KIND_MARKER;
                end else if (data_byte == cfg.file_marker) begin
                    phase_next    = PH_FILE_NAME;
                    res.byte_kind = KIND_MARKER;
                end else begin
                    phase_next = PH_ERR_PARSE;
                end
            end
            PH_DIR_NAME: begin
                if (is_sep) begin
                    phase_next    = PH_AWAIT;
                    res.byte_kind = KIND_DIR_END;
                end else begin
                    res.byte_kind = KIND_DIR_NAME;
                end
            end
            PH_FILE_NAME: begin
                if (is_sep) begin
                    phase_next      = PH_LENGTH;
                    length_next     = '0;
                    digit_seen_next = 1'b0;
                end
                res.byte_kind = KIND_FILE_NAME;
            end
            PH_LENGTH: begin
                if (is_sep) begin
                    if (!digit_eff) begin
                        phase_next = PH_ERR_PARSE;
                    end else begin
                        res.byte_kind   = KIND_LEN_END;
                        res.file_length = flen_wide[31:0];
                        digit_seen_next = 1'b0;
                        phase_next      = (length_eff == '0) ? PH_SKIP : PH_CONTENT;
                    end
                end else if (is_digit) begin
                    if (overflow) begin
                        phase_next = PH_ERR_SIZE;
                    end else begin
                        length_next     = scaled[LENGTH_BITS-1:0];
                        digit_seen_next = 1'b1;
                        res.byte_kind   = KIND_LEN_DIGIT;
                    end
                end else begin
                    phase_next = PH_ERR_PARSE;
                end
            end
            PH_CONTENT: begin
                if (is_sep && length_eff == '0) begin
                    phase_next    = PH_AWAIT;
                    res.byte_kind = KIND_FILE_END;
                end else if (length_eff == '0) begin
                    phase_next = PH_ERR_SIZE;
                end else begin
                    length_next   = length_eff - LENGTH_BITS'(1);
                    res.byte_kind = KIND_CONTENT;
                end
            end
            PH_SKIP: begin
                phase_next    = PH_AWAIT;
                length_next   = '0;
                res.byte_kind = KIND_EMPTY_SKIP;
            end
            default: begin
                phase_next = phase_eff;
            end
        endcase

        if (res.byte_kind == KIND_ERROR) begin
            res.error_code = (phase_next == PH_ERR_SIZE) ? ERR_SIZE : ERR_PARSE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_AWAIT;
            length_reg     <= '0;
            digit_seen_reg <= 1'b0;
        end else if (in_valid) begin
            phase_reg      <= phase_next;
            length_reg     <= length_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

    `DAD_ASSERT(a_sticky_error,
        (in_valid && !start_flag &&
         (phase_reg == PH_ERR_PARSE || phase_reg == PH_ERR_SIZE)) |-> res.byte_kind == KIND_ERROR,
        "error phase left without start")
    `DAD_ASSERT(a_content_no_digit, (phase_reg == PH_CONTENT) |-> !digit_seen_reg,
        "digit flag still set during content")
    `DAD_ASSERT(a_skip_zero_len, (phase_reg == PH_SKIP) |-> length_reg == '0,
        "skip phase with nonzero length")
    `DAD_ASSERT(a_error_code_set, (res.byte_kind == KIND_ERROR) |-> res.error_code != ERR_NONE,
        "error kind without error code")

endmodule

`default_nettype wire

### src/dad_out_stage.sv
`default_nettype none

module dad_out_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dad_pkg::res_t in_res,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dad_pkg::res_t      out_res
);
    import dad_pkg::*;

    `include "directory_archive_deframer_top_defines.svh"

    res_t out_res_reg;
    res_t skid_res_reg;
    logic out_valid_reg;
    logic skid_valid_reg;
    logic out_free;
    logic in_take;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_take;
            end
        end else if (in_take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end
        if (!out_free && in_take) begin
            skid_res_reg <= in_res;
        end
    end

    `DAD_ASSERT_ALWAYS(a_skid_needs_out, skid_valid_reg |-> out_valid_reg,
        "skid holds data while output is empty")
    `DAD_ASSERT(a_stall_to_skid, (in_take && out_valid_reg && !out_ready) |=> skid_valid_reg,
        "transaction taken during stall was not parked")
    `DAD_ASSERT(a_skid_drains, (skid_valid_reg && out_ready) |=> out_valid_reg && !skid_valid_reg,
        "skid entry did not move to output")

endmodule

`default_nettype wire

### src/directory_archive_deframer_top.sv
`default_nettype none

// Channel   Ports           tdata (low bit up)                       tuser
// input     s_t*            [7:0] data_byte                          [0] start_flag
// output    m_t*            [7:0] echo_byte, [39:8] file_length,     [3:0] byte_kind
//                           [41:40] error_code, [47:42] zero
// config    APB p*          regs at 0x0 separator, 0x4 dir marker, 0x8 file marker
//
// One byte per clock while s_tready is high: each accepted transaction is classified in
// the cycle it is taken and loaded at that same edge into the output register, offered
// from the next cycle on, or into the skid entry while the output stalls.
// Throughput is set by the parser's state feedback loop (one byte per update).
// The output register plus a one-entry skid keep s_tready high while a result
// waits; s_tready drops only when both are full.
// aresetn is synchronous, active low; it empties the output path, returns the
// parser to await a record marker and loads the register reset values.
// start_flag on a byte clears the parser before that byte is handled.
module directory_archive_deframer_top #(
    parameter int LENGTH_BITS = dad_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [7:0]                        s_tdata,  // [7:0] data_byte
    input  wire logic [0:0]                        s_tuser,  // [0] start_flag
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [47:0]                            m_tdata,  // echo_byte, file_length, error_code
    output logic [3:0]                             m_tuser,  // [3:0] byte_kind
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [dad_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [dad_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [dad_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready
);
    import dad_pkg::*;

    cfg_t cfg;
    res_t parse_res;
    res_t out_res;
    logic s_accept;

    // a transaction advances the parser only when the output path can hold it
    assign s_accept = s_tvalid && s_tready;

    dad_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dad_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_accept),
        .data_byte  (s_tdata),
        .start_flag (s_tuser[0]),
        .cfg        (cfg),
        .res        (parse_res)
    );

    dad_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // pack the result fields, zero-fill to whole bytes
    assign m_tdata = {6'd0, out_res.error_code, out_res.file_length, out_res.echo_byte};
    assign m_tuser = out_res.byte_kind;

endmodule

`default_nettype wire
